// ----- rtl/rom_pkg.sv -----
// rom_pkg: shared constants and types for the rank-one minor search block.
// No dependencies.
package rom_pkg;
    localparam int MAX_ROWS_DEF    = 16;
    localparam int MAX_COLUMNS_DEF = 16;
    localparam int COEF_WIDTH_DEF  = 64;
    localparam int CFG_W           = 5;
    localparam int IDX_W           = 4;
    localparam int STATUS_W        = 2;

    typedef enum logic [0:0] {
        REG_ROW_COUNT    = 1'b0,
        REG_COLUMN_COUNT = 1'b1
    } reg_index_t;

    localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    // front to back: a full matrix is in the store, search it
    typedef struct packed {
        logic [6:0] rows;
        logic [6:0] cols;
    } job_t;
endpackage

// ----- rtl/rom_front.sv -----
// rom_front: accepts coefficients, counts elements and writes the matrix store.
// Depends on rom_pkg.
module rom_front #(
    parameter int MAX_ROWS    = rom_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = rom_pkg::MAX_COLUMNS_DEF,
    parameter int COEF_WIDTH  = rom_pkg::COEF_WIDTH_DEF,
    parameter int ADDR_W      = $clog2(MAX_ROWS * MAX_COLUMNS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_take,
    input  logic [63:0]           coefficient,
    input  logic [6:0]            rows,
    input  logic [6:0]            cols,
    input  logic                  clear,
    output logic                  wr_en,
    output logic [ADDR_W-1:0]     wr_addr,
    output logic [COEF_WIDTH-1:0] wr_data,
    output logic                  job_valid,
    output rom_pkg::job_t         job
);
    logic [ADDR_W:0] count_reg, count_next;
    logic [ADDR_W:0] total;
    logic [ADDR_W:0] cur;

    assign total = (ADDR_W+1)'(rows) * (ADDR_W+1)'(cols);
    assign cur   = (count_reg >= total) ? '0 : count_reg;
    assign wr_en   = in_take;
    assign wr_addr = cur[ADDR_W-1:0];
    assign wr_data = coefficient[COEF_WIDTH-1:0];
    assign job_valid = in_take && (cur + 1'b1 == total);
    assign job.rows = rows;
    assign job.cols = cols;

    always_comb
    begin
        count_next = count_reg;
        if (clear)
            count_next = '0;
        else if (in_take)
            count_next = job_valid ? '0 : cur + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end
endmodule

// ----- rtl/rom_back.sv -----
// rom_back: sequencer over 2x2 minors with a shared checked multiplier,
// up to a nonzero minor or overflow; holds the matrix store; needs rom_pkg.
module rom_back #(
    parameter int MAX_ROWS    = rom_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = rom_pkg::MAX_COLUMNS_DEF,
    parameter int COEF_WIDTH  = rom_pkg::COEF_WIDTH_DEF,
    parameter int ADDR_W      = $clog2(MAX_ROWS * MAX_COLUMNS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [COEF_WIDTH-1:0] wr_data,
    input  logic                  job_valid,
    input  rom_pkg::job_t         job,
    output logic                  busy,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [3:0]            first_row,
    output logic [3:0]            second_row,
    output logic [3:0]            first_column,
    output logic [3:0]            second_column,
    output logic [63:0]           minor_value
);
    localparam int W  = COEF_WIDTH;
    localparam int HW = (W + 1) / 2;
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLUMNS);

    typedef enum logic [3:0] {
        S_IDLE, S_RDA, S_RDB, S_MUL1, S_RDC, S_RDD, S_MUL2, S_P1, S_P2,
        S_P3, S_SUB, S_NEXT, S_OUT
    } state_t;

    logic [W-1:0] mem [MAX_ROWS*MAX_COLUMNS];
    logic [W-1:0] rd_reg;
    logic [ADDR_W-1:0] rd_addr;

    state_t state_reg;
    logic [6:0] rows_reg, cols_reg;
    logic [RW-1:0] r0_reg, r1_reg;
    logic [CW-1:0] c0_reg, c1_reg;
    logic [W-1:0] a_reg, b_reg, dg_reg, od_reg;
    logic [1:0] pass_reg;
    logic [W-1:0] ma_reg, mb_reg;
    logic neg_reg;
    logic [2*HW-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [1:0] st_reg;
    logic [W-1:0] minor_reg;
    logic [2*W+1:0] wide;
    logic [W-1:0] lo;
    logic ovf;
    logic [W-1:0] lim;
    logic [W:0] diff;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    // product magnitude from four half-width partial products
    always_comb
    begin
        wide = (2*W+2)'(p00_reg) + ((2*W+2)'(p01_reg) << HW)
             + ((2*W+2)'(p10_reg) << HW) + ((2*W+2)'(p11_reg) << (2*HW));
        lo   = wide[W-1:0];
        lim  = {1'b1, {(W-1){1'b0}}} - {{(W-1){1'b0}}, !neg_reg};
        ovf  = (wide[2*W+1:W] != '0) || (lo > lim);
        diff = {dg_reg[W-1], dg_reg} - {od_reg[W-1], od_reg};
    end

    always_comb
    begin
        unique case (state_reg)
            S_RDA:   rd_addr = ADDR_W'(r0_reg) * ADDR_W'(cols_reg) + ADDR_W'(c0_reg);
            S_RDB:   rd_addr = ADDR_W'(r1_reg) * ADDR_W'(cols_reg) + ADDR_W'(c1_reg);
            S_RDC:   rd_addr = ADDR_W'(r0_reg) * ADDR_W'(cols_reg) + ADDR_W'(c1_reg);
            default: rd_addr = ADDR_W'(r1_reg) * ADDR_W'(cols_reg) + ADDR_W'(c0_reg);
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status    = st_reg;
    assign first_row     = (st_reg == rom_pkg::ST_NONZERO) ? 4'(r0_reg) : 4'd0;
    assign second_row    = (st_reg == rom_pkg::ST_NONZERO) ? 4'(r1_reg) : 4'd0;
    assign first_column  = (st_reg == rom_pkg::ST_NONZERO) ? 4'(c0_reg) : 4'd0;
    assign second_column = (st_reg == rom_pkg::ST_NONZERO) ? 4'(c1_reg) : 4'd0;
    assign minor_value   = (st_reg == rom_pkg::ST_NONZERO) ? 64'($signed(minor_reg)) : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= rom_pkg::ST_ZERO;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (job_valid)
                    begin
                        rows_reg <= job.rows;
                        cols_reg <= job.cols;
                        r0_reg <= '0; r1_reg <= RW'(1);
                        c0_reg <= '0; c1_reg <= CW'(1);
                        st_reg <= rom_pkg::ST_ZERO;
                        if (job.rows < 7'd2 || job.cols < 7'd2)
                            state_reg <= S_OUT;
                        else
                            state_reg <= S_RDA;
                    end
                S_RDA:  state_reg <= S_RDB;
                S_RDB:
                begin
                    a_reg <= rd_reg;
                    state_reg <= S_RDC;
                end
                S_RDC:
                begin
                    b_reg <= rd_reg;
                    pass_reg <= 2'd0;
                    state_reg <= S_RDD;
                end
                S_RDD:
                begin
                    // first product setup; rd_reg now holds a[r0][c1]
                    a_reg <= rd_reg;
                    b_reg <= a_reg;
                    ma_reg <= a_reg[W-1] ? -a_reg : a_reg;
                    mb_reg <= b_reg[W-1] ? -b_reg : b_reg;
                    neg_reg <= a_reg[W-1] ^ b_reg[W-1];
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    b_reg <= rd_reg;
                    state_reg <= S_P1;
                end
                S_P1:
                begin
                    p00_reg <= (2*HW)'(ma_reg[HW-1:0]) * (2*HW)'(mb_reg[HW-1:0]);
                    p01_reg <= (2*HW)'(ma_reg[HW-1:0]) * (2*HW)'(mb_reg[W-1:HW]);
                    state_reg <= S_P2;
                end
                S_P2:
                begin
                    p10_reg <= (2*HW)'(ma_reg[W-1:HW]) * (2*HW)'(mb_reg[HW-1:0]);
                    p11_reg <= (2*HW)'(ma_reg[W-1:HW]) * (2*HW)'(mb_reg[W-1:HW]);
                    state_reg <= S_P3;
                end
                S_P3:
                begin
                    if (ovf)
                    begin
                        st_reg <= rom_pkg::ST_OVERFLOW;
                        state_reg <= S_OUT;
                    end
                    else if (pass_reg == 2'd0)
                    begin
                        dg_reg <= neg_reg ? -lo : lo;
                        pass_reg <= 2'd1;
                        ma_reg <= a_reg[W-1] ? -a_reg : a_reg;
                        mb_reg <= b_reg[W-1] ? -b_reg : b_reg;
                        neg_reg <= a_reg[W-1] ^ b_reg[W-1];
                        state_reg <= S_P1;
                    end
                    else
                    begin
                        od_reg <= neg_reg ? -lo : lo;
                        state_reg <= S_SUB;
                    end
                end
                S_SUB:
                begin
                    minor_reg <= diff[W-1:0];
                    if (diff[W] != diff[W-1])
                    begin
                        st_reg <= rom_pkg::ST_OVERFLOW;
                        state_reg <= S_OUT;
                    end
                    else if (diff[W-1:0] != '0)
                    begin
                        st_reg <= rom_pkg::ST_NONZERO;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    state_reg <= S_RDA;
                    if (7'(c1_reg) + 7'd1 < cols_reg)
                        c1_reg <= c1_reg + 1'b1;
                    else if (7'(c0_reg) + 7'd2 < cols_reg)
                    begin
                        c0_reg <= c0_reg + 1'b1;
                        c1_reg <= c0_reg + CW'(2);
                    end
                    else if (7'(r1_reg) + 7'd1 < rows_reg)
                    begin
                        r1_reg <= r1_reg + 1'b1;
                        c0_reg <= '0; c1_reg <= CW'(1);
                    end
                    else if (7'(r0_reg) + 7'd2 < rows_reg)
                    begin
                        r0_reg <= r0_reg + 1'b1;
                        r1_reg <= r0_reg + RW'(2);
                        c0_reg <= '0; c1_reg <= CW'(1);
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                    if (!out_stall)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/rank_one_minor_search.sv -----
// rank_one_minor_search: top level, config registers, front loader and back search.
// Depends on rom_pkg, rom_front, rom_back.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  input    | in_valid / in_stall      | coefficient
//  config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//  result   | out_valid / out_stall    | status, rows, columns, minor_value
//
// Loading takes one item per cycle while the input is not stalled. After the
// last element the back end walks the minors, each as four store reads plus one
// register stage, two products each formed from partial products and then checked,
// one checked subtract and one index step; a full 16x16 search covers up to 14400
// minors. Input stalls while a search or an undelivered result is pending.
// Reset clears counters and sets both size registers to 1; the store needs no
// clearing pass. Config writes are always accepted.
module rank_one_minor_search #(
    parameter int MAX_ROWS    = rom_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = rom_pkg::MAX_COLUMNS_DEF,
    parameter int COEF_WIDTH  = rom_pkg::COEF_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] coefficient,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  first_row,
    output logic [3:0]  second_row,
    output logic [3:0]  first_column,
    output logic [3:0]  second_column,
    output logic [63:0] minor_value
);
    localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLUMNS);

    logic [4:0] row_count_reg, column_count_reg;
    logic [6:0] rows, cols;
    logic in_take, busy, job_valid, wr_en, cfg_take;
    logic [ADDR_W-1:0] wr_addr;
    logic [COEF_WIDTH-1:0] wr_data;
    rom_pkg::job_t job;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid;
    assign in_stall  = busy;
    assign in_take   = in_valid && !busy;

    // clamp sizes into 1..MAX
    assign rows = (row_count_reg == 5'd0) ? 7'd1 :
                  (7'(row_count_reg) > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : 7'(row_count_reg);
    assign cols = (column_count_reg == 5'd0) ? 7'd1 :
                  (7'(column_count_reg) > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS)
                                                          : 7'(column_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= 5'd1;
            column_count_reg <= 5'd1;
        end
        else if (cfg_take)
        begin
            unique case (rom_pkg::reg_index_t'(cfg_index))
                rom_pkg::REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                rom_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rom_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS), .COEF_WIDTH(COEF_WIDTH))
    u_front (
        .clk(clk), .rst_n(rst_n), .in_take(in_take), .coefficient(coefficient),
        .rows(rows), .cols(cols), .clear(cfg_take), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_data(wr_data), .job_valid(job_valid), .job(job)
    );

    rom_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS), .COEF_WIDTH(COEF_WIDTH))
    u_back (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .job_valid(job_valid), .job(job), .busy(busy), .out_valid(out_valid),
        .out_stall(out_stall), .status(status), .first_row(first_row),
        .second_row(second_row), .first_column(first_column),
        .second_column(second_column), .minor_value(minor_value)
    );
endmodule

// ----- rtl/rom_checker.sv -----
// rom_checker: port-level assertions for rank_one_minor_search, bound to the top.
// Depends on rom_pkg and the top level's ports.
module rom_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [3:0]  first_row,
    input logic [3:0]  second_row,
    input logic [63:0] minor_value
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(minor_value))
        else $error("result changed while stalled");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == rom_pkg::ST_ZERO || status == rom_pkg::ST_NONZERO
                       || status == rom_pkg::ST_OVERFLOW))
        else $error("bad status");
    a_rows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == rom_pkg::ST_NONZERO |->
            first_row < second_row && minor_value != 64'd0)
        else $error("bad minor report");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");
endmodule

bind rank_one_minor_search rom_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .first_row(first_row), .second_row(second_row), .minor_value(minor_value)
);
